>>> rtl/core/atsf_pkg.sv
// atsf_pkg: types and constants for the alarm set menu and alarm match core.
// No dependencies; used by every module of the core.

package atsf_pkg;

    localparam int unsigned HourW   = 5;
    localparam int unsigned MinuteW = 6;
    localparam int unsigned RowW    = 2;
    localparam int unsigned FieldW  = 2;

    localparam logic [HourW-1:0]   HourMax     = HourW'(23);
    localparam logic [HourW-1:0]   HourReset   = HourW'(6);
    localparam logic [MinuteW-1:0] MinuteMax   = MinuteW'(59);
    localparam logic [MinuteW:0]   MinuteMod   = (MinuteW + 1)'(60);
    localparam logic [MinuteW-1:0] MinuteTens  = MinuteW'(10);
    localparam logic [MinuteW-1:0] MinuteUnits = MinuteW'(1);

    localparam logic [RowW-1:0] RowEnable = RowW'(0);
    localparam logic [RowW-1:0] RowSet    = RowW'(1);
    localparam logic [RowW-1:0] RowEdit   = RowW'(2);

    localparam logic [FieldW-1:0] FieldHour  = FieldW'(0);
    localparam logic [FieldW-1:0] FieldTens  = FieldW'(1);
    localparam logic [FieldW-1:0] FieldUnits = FieldW'(2);

    typedef struct packed {
        logic               press_prev;
        logic               press_next;
        logic               press_select;
        logic               press_exit;
        logic               check_time;
        logic [HourW-1:0]   now_hour;
        logic [MinuteW-1:0] now_minute;
    } in_item_t;

    typedef struct packed {
        logic               alarm_enabled;
        logic [HourW-1:0]   alarm_hour_out;
        logic [MinuteW-1:0] alarm_minute_out;
        logic [RowW-1:0]    menu_row;
        logic [FieldW-1:0]  edit_field;
        logic [HourW-1:0]   edit_hour;
        logic [MinuteW-1:0] edit_minute;
        logic               alarm_fire;
        logic               exit_request;
    } out_item_t;

    typedef struct packed {
        logic               armed;
        logic [HourW-1:0]   set_hour;
        logic [MinuteW-1:0] set_minute;
        logic [RowW-1:0]    row_select;
        logic [FieldW-1:0]  field_select;
        logic [HourW-1:0]   work_hour;
        logic [MinuteW-1:0] work_minute;
    } state_t;

    function automatic logic [MinuteW-1:0] min_add(input logic [MinuteW-1:0] m,
                                                   input logic [MinuteW-1:0] d);
        logic [MinuteW:0] s;
        s = {1'b0, m} + {1'b0, d};
        return (s > {1'b0, MinuteMax}) ? MinuteW'(s - MinuteMod) : MinuteW'(s);
    endfunction

    function automatic logic [MinuteW-1:0] min_sub(input logic [MinuteW-1:0] m,
                                                   input logic [MinuteW-1:0] d);
        logic [MinuteW:0] s;
        s = {1'b0, m} + MinuteMod - {1'b0, d};
        return (m >= d) ? (m - d) : MinuteW'(s);
    endfunction

endpackage

>>> rtl/core/atsf_step.sv
// atsf_step: one request's state update (buttons, then time check).
// Depends on atsf_pkg.

module atsf_step (
    input  atsf_pkg::state_t   cur,
    input  atsf_pkg::in_item_t req,
    output atsf_pkg::state_t   nxt,
    output logic               fire
);

    always_comb begin
        nxt  = cur;
        fire = 1'b0;
        if (cur.row_select < atsf_pkg::RowEdit) begin
            if (req.press_prev) begin
                nxt.row_select = (nxt.row_select == atsf_pkg::RowEnable) ?
                                 atsf_pkg::RowSet : atsf_pkg::RowEnable;
            end
            if (req.press_next) begin
                nxt.row_select = (nxt.row_select == atsf_pkg::RowSet) ?
                                 atsf_pkg::RowEnable : atsf_pkg::RowSet;
            end
            if (req.press_select) begin
                if (nxt.row_select == atsf_pkg::RowEnable) begin
                    nxt.armed = ~nxt.armed;
                end else begin
                    nxt.row_select   = atsf_pkg::RowEdit;
                    nxt.field_select = atsf_pkg::FieldHour;
                    nxt.work_hour    = cur.set_hour;
                    nxt.work_minute  = cur.set_minute;
                end
            end
        end else begin
            if (req.press_prev) begin
                priority if (cur.field_select == atsf_pkg::FieldHour) begin
                    nxt.work_hour = (nxt.work_hour >= atsf_pkg::HourMax) ?
                                    '0 : nxt.work_hour + 1'b1;
                end else if (cur.field_select == atsf_pkg::FieldTens) begin
                    nxt.work_minute = atsf_pkg::min_add(nxt.work_minute,
                                                        atsf_pkg::MinuteTens);
                end else if (cur.field_select == atsf_pkg::FieldUnits) begin
                    nxt.work_minute = atsf_pkg::min_add(nxt.work_minute,
                                                        atsf_pkg::MinuteUnits);
                end else begin
                    nxt.work_hour = nxt.work_hour;
                end
            end
            if (req.press_next) begin
                priority if (cur.field_select == atsf_pkg::FieldHour) begin
                    nxt.work_hour = (nxt.work_hour == '0 ||
                                     nxt.work_hour > atsf_pkg::HourMax) ?
                                    atsf_pkg::HourMax : nxt.work_hour - 1'b1;
                end else if (cur.field_select == atsf_pkg::FieldTens) begin
                    nxt.work_minute = atsf_pkg::min_sub(nxt.work_minute,
                                                        atsf_pkg::MinuteTens);
                end else if (cur.field_select == atsf_pkg::FieldUnits) begin
                    nxt.work_minute = atsf_pkg::min_sub(nxt.work_minute,
                                                        atsf_pkg::MinuteUnits);
                end else begin
                    nxt.work_hour = nxt.work_hour;
                end
            end
            if (req.press_select) begin
                if (cur.field_select >= atsf_pkg::FieldUnits) begin
                    nxt.field_select = atsf_pkg::FieldHour;
                    nxt.row_select   = atsf_pkg::RowSet;
                    nxt.set_hour     = nxt.work_hour;
                    nxt.set_minute   = nxt.work_minute;
                end else begin
                    nxt.field_select = cur.field_select + 1'b1;
                end
            end
        end
        if (req.check_time && nxt.armed && nxt.set_hour == req.now_hour &&
            nxt.set_minute == req.now_minute) begin
            fire      = 1'b1;
            nxt.armed = 1'b0;
        end
    end

endmodule

>>> rtl/core/alarm_time_setting_fsm_core.sv
// alarm_time_setting_fsm_core: top level; input register, state, result register.
// Depends on atsf_pkg and atsf_step.
//
//  channel | ports                     | payload
//  input   | s_valid, s_ready, s_data  | atsf_pkg::in_item_t
//  result  | m_valid, m_ready, m_data  | atsf_pkg::out_item_t
//
// One request per cycle sustained unless m_ready stalls the result register.
// The state update is one combinational pass between input and result register.
// Reset (aresetn low, synchronous) empties both registers and restores the state.
// A stalled result holds the input register; s_ready drops only while both are full.

module alarm_time_setting_fsm_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  atsf_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output atsf_pkg::out_item_t  m_data
);

    logic                in_valid_reg;
    atsf_pkg::in_item_t  in_data_reg;
    atsf_pkg::state_t    state_reg;
    atsf_pkg::state_t    state_next;
    logic                m_valid_reg;
    atsf_pkg::out_item_t m_data_reg;
    logic                fire;
    logic                advance;

    atsf_step u_step (
        .cur  (state_reg),
        .req  (in_data_reg),
        .nxt  (state_next),
        .fire (fire)
    );

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg           <= 1'b0;
            m_valid_reg            <= 1'b0;
            state_reg.armed        <= 1'b0;
            state_reg.set_hour     <= atsf_pkg::HourReset;
            state_reg.set_minute   <= '0;
            state_reg.row_select   <= atsf_pkg::RowEnable;
            state_reg.field_select <= atsf_pkg::FieldHour;
            state_reg.work_hour    <= '0;
            state_reg.work_minute  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_data_reg  <= s_data;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg                   <= state_next;
                m_valid_reg                 <= 1'b1;
                m_data_reg.alarm_enabled    <= state_next.armed;
                m_data_reg.alarm_hour_out   <= state_next.set_hour;
                m_data_reg.alarm_minute_out <= state_next.set_minute;
                m_data_reg.menu_row         <= state_next.row_select;
                m_data_reg.edit_field       <= state_next.field_select;
                m_data_reg.edit_hour        <= state_next.work_hour;
                m_data_reg.edit_minute      <= state_next.work_minute;
                m_data_reg.alarm_fire       <= fire;
                m_data_reg.exit_request     <= in_data_reg.press_exit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/core/atsf_checker.sv
// atsf_checker: port-level assertions for alarm_time_setting_fsm_core, and its bind.
// Depends on atsf_pkg.

module atsf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input atsf_pkg::out_item_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_fire_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.alarm_fire |-> !m_data.alarm_enabled)
        else $error("alarm still armed after firing");

    a_field_menu: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.menu_row != atsf_pkg::RowEdit |->
        m_data.edit_field == atsf_pkg::FieldHour)
        else $error("edit field set outside edit mode");

    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.alarm_hour_out <= atsf_pkg::HourMax &&
        m_data.alarm_minute_out <= atsf_pkg::MinuteMax &&
        m_data.edit_hour <= atsf_pkg::HourMax &&
        m_data.edit_minute <= atsf_pkg::MinuteMax &&
        m_data.menu_row <= atsf_pkg::RowEdit)
        else $error("result field out of range");

endmodule

bind alarm_time_setting_fsm_core atsf_checker u_atsf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> sim/alarm_time_setting_fsm_core_test.sv
// Testbench for alarm_time_setting_fsm_core: directed and random requests with random gaps and
// stalls on both channels, each result checked against a cycle-free alarm menu predictor.
// Depends on atsf_pkg and the core RTL.

module alarm_time_setting_fsm_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HoldAt     = 600;
    localparam int HoldCycles = 100;
    localparam int Items      = 1600;

    class alarm_status_board;
        atsf_pkg::state_t    st;
        atsf_pkg::out_item_t expected_status[$];
        int                  errors;

        function new();
            st = '0;
            st.set_hour = atsf_pkg::HourReset;
            errors = 0;
        endfunction

        function int wrap_step(int value, int delta, int modulus);
            return (value + modulus + delta) % modulus;
        endfunction

        function void step_field(int dir);
            case (st.field_select)
                atsf_pkg::FieldHour:
                    st.work_hour = atsf_pkg::HourW'(wrap_step(st.work_hour, dir,
                                       atsf_pkg::HourMax + 1));
                atsf_pkg::FieldTens:
                    st.work_minute = atsf_pkg::MinuteW'(wrap_step(st.work_minute,
                                         dir * int'(atsf_pkg::MinuteTens),
                                         atsf_pkg::MinuteMax + 1));
                atsf_pkg::FieldUnits:
                    st.work_minute = atsf_pkg::MinuteW'(wrap_step(st.work_minute,
                                         dir * int'(atsf_pkg::MinuteUnits),
                                         atsf_pkg::MinuteMax + 1));
                default: ;
            endcase
        endfunction

        function void note_request(atsf_pkg::in_item_t req);
            atsf_pkg::out_item_t res;
            res = '0;
            if (st.row_select == atsf_pkg::RowEnable || st.row_select == atsf_pkg::RowSet) begin
                if (req.press_prev)
                    st.row_select = (st.row_select == atsf_pkg::RowEnable) ?
                                    atsf_pkg::RowSet : atsf_pkg::RowEnable;
                if (req.press_next)
                    st.row_select = (st.row_select == atsf_pkg::RowSet) ?
                                    atsf_pkg::RowEnable : atsf_pkg::RowSet;
                if (req.press_select) begin
                    if (st.row_select == atsf_pkg::RowEnable) begin
                        st.armed = ~st.armed;
                    end else begin
                        st.row_select   = atsf_pkg::RowEdit;
                        st.field_select = atsf_pkg::FieldHour;
                        st.work_hour    = st.set_hour;
                        st.work_minute  = st.set_minute;
                    end
                end
            end else begin
                if (req.press_prev)
                    step_field(1);
                if (req.press_next)
                    step_field(-1);
                if (req.press_select) begin
                    if (st.field_select >= atsf_pkg::FieldUnits) begin
                        st.field_select = atsf_pkg::FieldHour;
                        st.row_select   = atsf_pkg::RowSet;
                        st.set_hour     = st.work_hour;
                        st.set_minute   = st.work_minute;
                    end else begin
                        st.field_select = st.field_select + 1'b1;
                    end
                end
            end
            if (req.check_time && st.armed && st.set_hour == req.now_hour &&
                st.set_minute == req.now_minute) begin
                res.alarm_fire = 1'b1;
                st.armed = 1'b0;
            end
            res.alarm_enabled    = st.armed;
            res.alarm_hour_out   = st.set_hour;
            res.alarm_minute_out = st.set_minute;
            res.menu_row         = st.row_select;
            res.edit_field       = st.field_select;
            res.edit_hour        = st.work_hour;
            res.edit_minute      = st.work_minute;
            res.exit_request     = req.press_exit;
            expected_status.push_back(res);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_status(atsf_pkg::out_item_t got);
            atsf_pkg::out_item_t want;
            if (expected_status.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = expected_status.pop_front();
            compare_field("alarm_enabled", want.alarm_enabled, got.alarm_enabled);
            compare_field("alarm_hour_out", want.alarm_hour_out, got.alarm_hour_out);
            compare_field("alarm_minute_out", want.alarm_minute_out, got.alarm_minute_out);
            compare_field("menu_row", want.menu_row, got.menu_row);
            compare_field("edit_field", want.edit_field, got.edit_field);
            compare_field("edit_hour", want.edit_hour, got.edit_hour);
            compare_field("edit_minute", want.edit_minute, got.edit_minute);
            compare_field("alarm_fire", want.alarm_fire, got.alarm_fire);
            compare_field("exit_request", want.exit_request, got.exit_request);
        endfunction
    endclass

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    atsf_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    atsf_pkg::out_item_t m_data;

    alarm_status_board board = new();

    alarm_time_setting_fsm_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // no idling in a burst window and around the receiver hold-off
    function automatic int pick_gap(int idx);
        if ((idx >= 300 && idx < 420) || (idx >= HoldAt - 40 && idx < HoldAt + 160))
            return 0;
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic atsf_pkg::in_item_t mk(bit prev, bit next, bit sel, bit ex, bit chk,
                                              int hour, int minute);
        atsf_pkg::in_item_t r;
        r.press_prev   = prev;
        r.press_next   = next;
        r.press_select = sel;
        r.press_exit   = ex;
        r.check_time   = chk;
        r.now_hour     = atsf_pkg::HourW'(hour);
        r.now_minute   = atsf_pkg::MinuteW'(minute);
        return r;
    endfunction

    function automatic atsf_pkg::in_item_t random_request();
        atsf_pkg::in_item_t r;
        int                 pick;
        r.press_prev   = ($urandom_range(0, 3) == 0);
        r.press_next   = ($urandom_range(0, 3) == 0);
        r.press_select = ($urandom_range(0, 3) == 0);
        r.press_exit   = ($urandom_range(0, 5) == 0);
        r.check_time   = ($urandom_range(0, 1) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            r.now_hour   = board.st.set_hour;
            r.now_minute = board.st.set_minute;
        end else if (pick < 9) begin
            r.now_hour   = atsf_pkg::HourW'($urandom_range(0, atsf_pkg::HourMax));
            r.now_minute = atsf_pkg::MinuteW'($urandom_range(0, atsf_pkg::MinuteMax));
        end else begin
            r.now_hour   = atsf_pkg::HourW'($urandom);
            r.now_minute = atsf_pkg::MinuteW'($urandom);
        end
        return r;
    endfunction

    // called at the edge that accepted the previous request
    task automatic offer(atsf_pkg::in_item_t req, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        board.note_request(req);
    endtask

    task automatic drain_results();
        int gap;
        int taken;
        taken = 0;
        forever begin
            gap = (taken == HoldAt) ? HoldCycles : pick_gap(taken);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_status(m_data);
            taken++;
        end
    endtask

    initial begin
        #5_000_000;
        $display("alarm_time_setting_fsm_core_test: FAIL");
        $finish;
    end

    initial begin
        atsf_pkg::in_item_t dir_q[$];
        int                 idx;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            drain_results();
        join_none

        dir_q.push_back(mk(0, 0, 0, 1, 1, 6, 0));     // exit only, disarmed check
        dir_q.push_back(mk(0, 0, 1, 0, 0, 0, 0));     // arm
        dir_q.push_back(mk(0, 0, 0, 0, 1, 6, 0));     // match fires and disarms
        dir_q.push_back(mk(0, 0, 1, 0, 1, 31, 63));   // arm, time out of range
        dir_q.push_back(mk(0, 1, 1, 0, 0, 0, 0));     // set row, open edit
        repeat (6) dir_q.push_back(mk(0, 1, 0, 0, 0, 0, 0));
        dir_q.push_back(mk(0, 1, 0, 0, 0, 0, 0));     // hour 0 -> 23
        dir_q.push_back(mk(1, 0, 0, 0, 0, 0, 0));     // hour 23 -> 0
        dir_q.push_back(mk(0, 0, 1, 0, 0, 0, 0));     // to minute tens
        dir_q.push_back(mk(0, 1, 0, 0, 0, 0, 0));     // 0 - 10 -> 50
        dir_q.push_back(mk(1, 0, 0, 0, 0, 0, 0));     // 50 + 10 -> 0
        dir_q.push_back(mk(1, 1, 1, 0, 0, 0, 0));     // to minute units
        dir_q.push_back(mk(0, 1, 0, 0, 0, 0, 0));     // 0 - 1 -> 59
        dir_q.push_back(mk(1, 0, 0, 0, 0, 0, 0));     // 59 + 1 -> 0
        dir_q.push_back(mk(0, 1, 1, 0, 0, 0, 0));     // commit 0:59
        dir_q.push_back(mk(0, 0, 0, 1, 1, 0, 59));    // fire with exit
        dir_q.push_back(mk(1, 1, 1, 0, 0, 0, 0));     // row 1 -> 0 -> 1, open edit
        dir_q.push_back(mk(0, 0, 1, 1, 1, 23, 59));   // exit in edit

        idx = 0;
        foreach (dir_q[i]) begin
            offer(dir_q[i], pick_gap(idx));
            idx++;
        end
        while (idx < Items) begin
            offer(random_request(), pick_gap(idx));
            idx++;
        end
        s_valid <= 1'b0;

        while (board.expected_status.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (board.errors == 0) begin
            $display("alarm_time_setting_fsm_core_test: PASS");
        end else begin
            $display("alarm_time_setting_fsm_core_test: FAIL");
        end
        $finish;
    end
endmodule
